// File: design/lcd_serial_frame_packer_top_assert.svh
// Assertion macros for the serial LCD frame packer top level.
`ifndef LCD_SERIAL_FRAME_PACKER_TOP_ASSERT_SVH
`define LCD_SERIAL_FRAME_PACKER_TOP_ASSERT_SVH
`ifndef SYNTH
`define LCDSFP_ASSERT_NOW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LCDSFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define LCDSFP_ASSERT_NOW(lbl, prop, msg)
`define LCDSFP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/lcdsfp_pkg.sv
// Types and constants shared by the serial LCD frame packer.
`timescale 1ns / 1ps
package lcdsfp_pkg;

  localparam int unsigned MaxBits = 16;
  localparam int unsigned WordBits = 32;
  localparam logic [2:0] HdrCmd = 3'b100;
  localparam logic [2:0] HdrData = 3'b101;

  typedef enum logic [1:0] {
    REQ_RAW  = 2'd0,
    REQ_CMD  = 2'd1,
    REQ_DATA = 2'd2,
    REQ_END  = 2'd3
  } req_kind_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] value;
    logic [4:0]  bit_count;
    logic [5:0]  address;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       ends_transfer;
    logic       last;
  } out_t;

  // One classified request: bit string left aligned, result count minus one,
  // whether the request closes the transfer and whether the closing result has a byte.
  typedef struct packed {
    logic [WordBits-1:0] word;
    logic [1:0]          nres_m1;
    logic                closes;
    logic                close_has;
  } job_t;

endpackage

// File: design/lcdsfp_front.sv
// Front end: accepts requests, merges them with pending bits, builds jobs.
`timescale 1ns / 1ps
module lcdsfp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lcdsfp_pkg::in_t     req,
  output logic                full,
  input  logic                q_full,
  output logic                q_push,
  output lcdsfp_pkg::job_t    q_job
);
  import lcdsfp_pkg::*;

  logic [7:0]  pend_bits, pend_bits_next;
  logic [2:0]  pend_cnt, pend_cnt_next;
  req_kind_e   kind;
  logic [4:0]  cnt_sat;
  logic [16:0] mask;
  logic [15:0] vmask;
  logic [31:0] base, bits, comb_word;
  logic [2:0]  base_cnt;
  logic [4:0]  nbits;
  logic [5:0]  total;
  logic        closes;
  logic [2:0]  nres;
  logic [7:0]  res_mask;
  logic        accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign kind   = req_kind_e'(req.req_type);

  always_comb begin
    cnt_sat = (req.bit_count > 5'(MaxBits)) ? 5'(MaxBits) : req.bit_count;
    mask    = (17'd1 << cnt_sat) - 17'd1;
    vmask   = req.value & mask[15:0];
    base     = {24'd0, pend_bits};
    base_cnt = pend_cnt;
    nbits    = 5'd0;
    bits     = 32'd0;
    closes   = 1'b0;
    case (kind)
      REQ_RAW: begin
        nbits = cnt_sat;
        bits  = {16'd0, vmask};
      end
      REQ_CMD: begin
        base     = 32'd0;
        base_cnt = 3'd0;
        nbits    = 5'd12;
        bits     = {20'd0, HdrCmd, req.value[7:0], 1'b1};
        closes   = 1'b1;
      end
      REQ_DATA: begin
        base     = 32'd0;
        base_cnt = 3'd0;
        nbits    = 5'd9 + cnt_sat;
        bits     = ({23'd0, HdrData, req.address} << cnt_sat) | {16'd0, vmask};
      end
      REQ_END: begin
        closes = 1'b1;
      end
      default: begin
        closes = 1'b1;
      end
    endcase
    comb_word = (base << nbits) | bits;
    total     = {3'd0, base_cnt} + {1'b0, nbits};
    nres      = total[5:3] + {2'd0, closes};
    res_mask  = (8'd1 << total[2:0]) - 8'd1;

    q_job.word      = comb_word << (6'd32 - total);
    q_job.nres_m1   = 2'(nres - 3'd1);
    q_job.closes    = closes;
    q_job.close_has = (total[2:0] != 3'd0);
    q_push          = accept && (nres != 3'd0);

    pend_bits_next = pend_bits;
    pend_cnt_next  = pend_cnt;
    if (accept) begin
      pend_bits_next = closes ? 8'd0 : (comb_word[7:0] & res_mask);
      pend_cnt_next  = closes ? 3'd0 : total[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits <= 8'd0;
      pend_cnt  <= 3'd0;
    end else begin
      pend_bits <= pend_bits_next;
      pend_cnt  <= pend_cnt_next;
    end
  end

endmodule

// File: design/lcdsfp_queue.sv
// Two-entry job queue between front and back ends.
`timescale 1ns / 1ps
module lcdsfp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lcdsfp_pkg::job_t job_in,
  output logic             full,
  output logic             valid,
  output lcdsfp_pkg::job_t job_out,
  input  logic             pop
);
  import lcdsfp_pkg::*;

  job_t       e0, e1;
  logic [1:0] cnt, cnt_next;
  logic       do_push, do_pop;

  assign full    = (cnt == 2'd2);
  assign valid   = (cnt != 2'd0);
  assign job_out = e0;
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    cnt_next = cnt + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && (cnt == 2'd0 || (cnt == 2'd1 && do_pop))) begin
      e0 <= job_in;
    end else if (do_pop && cnt == 2'd2) begin
      e0 <= e1;
    end
    if (do_push && cnt == 2'd1 && !do_pop) begin
      e1 <= job_in;
    end
  end

endmodule

// File: design/lcdsfp_back.sv
// Back end: walks one job and presents its results one per cycle while pop is held.
`timescale 1ns / 1ps
module lcdsfp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  lcdsfp_pkg::job_t q_job,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output lcdsfp_pkg::out_t rsp
);
  import lcdsfp_pkg::*;

  job_t       cur;
  logic       busy;
  logic [1:0] k;
  logic       is_last, done, load;

  assign is_last = (k == cur.nres_m1);
  assign done    = busy && pop && is_last;
  assign load    = q_valid && (!busy || done);
  assign q_pop   = load;
  assign empty   = !busy;

  always_comb begin
    case (k)
      2'd0:    rsp.out_byte = cur.word[31:24];
      2'd1:    rsp.out_byte = cur.word[23:16];
      2'd2:    rsp.out_byte = cur.word[15:8];
      default: rsp.out_byte = cur.word[7:0];
    endcase
    rsp.has_byte      = (is_last && cur.closes) ? cur.close_has : 1'b1;
    rsp.ends_transfer = is_last && cur.closes;
    rsp.last          = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      k    <= 2'd0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy && pop) begin
      k <= k + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_job;
    end
  end

endmodule

// File: design/lcd_serial_frame_packer_top.sv
// Top level of the serial LCD frame packer.
//  channel  | handshake         | payload
//  request  | push / full       | req (in_t)
//  result   | pop / empty       | rsp (out_t)
// A request is taken every cycle while the two-entry job queue has room.
// Results leave one per cycle while pop is held; each job stays until its last pops.
// With the back end idle, a job passes a queue entry, then cur, before its first result.
// Synchronous reset clears pending bits, the queue and the back end.
// A request that completes no byte and closes no transfer yields no result and no job.
`timescale 1ns / 1ps
module lcd_serial_frame_packer_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  lcdsfp_pkg::in_t  req,
  output logic             empty,
  input  logic             pop,
  output lcdsfp_pkg::out_t rsp
);
  import lcdsfp_pkg::*;

  logic q_full, q_push, q_valid, q_pop;
  job_t f_job, b_job;

  lcdsfp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .req    (req),
    .full   (full),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (f_job)
  );

  lcdsfp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .job_in  (f_job),
    .full    (q_full),
    .valid   (q_valid),
    .job_out (b_job),
    .pop     (q_pop)
  );

  lcdsfp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (b_job),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .rsp     (rsp)
  );

`include "lcd_serial_frame_packer_top_assert.svh"

  `LCDSFP_ASSERT_NOW(a_end_is_last, !empty && rsp.ends_transfer |-> rsp.last, "end not last")
  `LCDSFP_ASSERT_NOW(a_bare_end, !empty && !rsp.has_byte |-> rsp.ends_transfer && rsp.out_byte == 8'd0, "bad bare end")
  `LCDSFP_ASSERT_NEXT(a_more_results, pop && !empty && !rsp.last, !empty, "results lost")

endmodule

// File: bench/lcd_serial_frame_packer_checker.sv
// Checker for the serial LCD frame packer: predicts packed bytes and compares results.
`timescale 1ns / 1ps
module lcd_serial_frame_packer_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             full,
  input  lcdsfp_pkg::in_t  req,
  input  logic             pop,
  input  logic             empty,
  input  lcdsfp_pkg::out_t rsp,
  output int               errors,
  output int               waiting,
  output int               results_seen
);
  import lcdsfp_pkg::*;

  logic [7:0] cur_bits;
  logic [3:0] cur_cnt;
  out_t       batch[$];
  out_t       byte_q[$];
  out_t       head;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 20) begin
      $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
    end
    errors++;
  endtask

  function automatic void emit_byte(input logic [7:0] b, input logic has, input logic ends);
    out_t r;
    r.out_byte = b;
    r.has_byte = has;
    r.ends_transfer = ends;
    r.last = 1'b0;
    if (batch.size() < 4) begin
      batch.push_back(r);
    end
  endfunction

  function automatic void shift_in(input logic [15:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      cur_bits = {cur_bits[6:0], v[i]};
      cur_cnt++;
      if (cur_cnt == 4'd8) begin
        emit_byte(cur_bits, 1'b1, 1'b0);
        cur_bits = '0;
        cur_cnt = '0;
      end
    end
  endfunction

  function automatic void close_transfer();
    if (cur_cnt != 0) begin
      emit_byte(cur_bits << (8 - cur_cnt), 1'b1, 1'b1);
    end else begin
      emit_byte(8'h00, 1'b0, 1'b1);
    end
    cur_bits = '0;
    cur_cnt = '0;
  endfunction

  function automatic void pack_request(input in_t r);
    int n;
    n = (r.bit_count > MaxBits) ? MaxBits : r.bit_count;
    batch.delete();
    case (req_kind_e'(r.req_type))
      REQ_RAW: begin
        shift_in(r.value, n);
      end
      REQ_CMD: begin
        cur_bits = '0;
        cur_cnt = '0;
        shift_in({13'd0, HdrCmd}, 3);
        shift_in({8'd0, r.value[7:0]}, 8);
        shift_in(16'd1, 1);
        close_transfer();
      end
      REQ_DATA: begin
        cur_bits = '0;
        cur_cnt = '0;
        shift_in({13'd0, HdrData}, 3);
        shift_in({10'd0, r.address}, 6);
        shift_in(r.value, n);
      end
      default: begin
        close_transfer();
      end
    endcase
    if (batch.size() > 0) begin
      batch[batch.size() - 1].last = 1'b1;
    end
    foreach (batch[i]) begin
      byte_q.push_back(batch[i]);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cur_bits = '0;
      cur_cnt = '0;
      byte_q.delete();
    end else begin
      if (push && !full) begin
        pack_request(req);
      end
      if (pop && !empty) begin
        results_seen++;
        if (byte_q.size() == 0) begin
          report_mismatch("result with no request outstanding", rsp, 0);
        end else begin
          head = byte_q.pop_front();
          if (rsp.out_byte !== head.out_byte) begin
            report_mismatch("out_byte", rsp.out_byte, head.out_byte);
          end
          if (rsp.has_byte !== head.has_byte) begin
            report_mismatch("has_byte", rsp.has_byte, head.has_byte);
          end
          if (rsp.ends_transfer !== head.ends_transfer) begin
            report_mismatch("ends_transfer", rsp.ends_transfer, head.ends_transfer);
          end
          if (rsp.last !== head.last) begin
            report_mismatch("last", rsp.last, head.last);
          end
        end
      end
    end
    waiting = byte_q.size();
  end

endmodule

// File: bench/lcd_serial_frame_packer_top_tb.sv
// Testbench top for the serial LCD frame packer: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module lcd_serial_frame_packer_top_tb;
  import lcdsfp_pkg::*;

  localparam int StallLimit = 2000;
  localparam int NumItems = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  in_t  req = '0;
  out_t rsp;

  int n_errors;
  int n_waiting;
  int n_results;
  int n_sent;
  int kind_cnt [4];
  int stall_cycles;
  bit gaps_on = 1'b1;
  bit paused_mid = 1'b0;

  lcd_serial_frame_packer_top dut (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .req  (req),
    .empty(empty),
    .pop  (pop),
    .rsp  (rsp)
  );

  lcd_serial_frame_packer_checker chk (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .req         (req),
    .pop         (pop),
    .empty       (empty),
    .rsp         (rsp),
    .errors      (n_errors),
    .waiting     (n_waiting),
    .results_seen(n_results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("lcd_serial_frame_packer_top_tb: errors");
        $finish;
      end
    end
  end

  function automatic in_t mk_req(input req_kind_e k, input logic [15:0] v,
                                 input logic [4:0] n, input logic [5:0] a);
    in_t r;
    r.req_type = k;
    r.value = v;
    r.bit_count = n;
    r.address = a;
    return r;
  endfunction

  function automatic logic [4:0] rand_count();
    if ($urandom_range(0, 7) == 0) begin
      return 5'($urandom_range(17, 31));
    end
    return 5'($urandom_range(0, 16));
  endfunction

  task automatic send_req(input in_t r);
    bit held;
    req <= r;
    push <= 1'b1;
    do begin
      @(negedge clk);
      held = full;
      @(posedge clk);
    end while (held);
    kind_cnt[r.req_type]++;
    n_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    do @(negedge clk); while (n_waiting != 0);
    @(posedge clk);
  endtask

  // result side: pop in bursts, stalling at random while gaps are enabled
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (gaps_on && $urandom_range(0, 2) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    int pick;
    int nraw;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_req(mk_req(REQ_RAW, 16'hFFFF, 5'd16, 6'd0));
    send_req(mk_req(REQ_RAW, 16'h0000, 5'd0, 6'd0));
    send_req(mk_req(REQ_RAW, 16'hA5C3, 5'd31, 6'd63));
    send_req(mk_req(REQ_RAW, 16'h0005, 5'd3, 6'd0));
    send_req(mk_req(REQ_END, 16'h0000, 5'd0, 6'd0));
    send_req(mk_req(REQ_END, 16'hFFFF, 5'd31, 6'd63));
    send_req(mk_req(REQ_RAW, 16'h0001, 5'd5, 6'd0));
    send_req(mk_req(REQ_CMD, 16'hFFAB, 5'd0, 6'd0));
    send_req(mk_req(REQ_CMD, 16'h0000, 5'd31, 6'd63));
    send_req(mk_req(REQ_DATA, 16'hFFFF, 5'd16, 6'd63));
    send_req(mk_req(REQ_END, 16'h0000, 5'd0, 6'd0));
    send_req(mk_req(REQ_DATA, 16'h0000, 5'd0, 6'd0));
    send_req(mk_req(REQ_END, 16'h0000, 5'd0, 6'd0));
    send_req(mk_req(REQ_DATA, 16'h1234, 5'd17, 6'd21));
    send_req(mk_req(REQ_RAW, 16'h007F, 5'd7, 6'd0));
    send_req(mk_req(REQ_END, 16'h0000, 5'd0, 6'd0));
    send_req(mk_req(REQ_RAW, 16'h00FF, 5'd8, 6'd0));
    send_req(mk_req(REQ_END, 16'h0000, 5'd0, 6'd0));
    send_req(mk_req(REQ_DATA, 16'hFFFF, 5'd31, 6'd42));
    send_req(mk_req(REQ_RAW, 16'h5555, 5'd16, 6'd0));
    send_req(mk_req(REQ_END, 16'h0000, 5'd0, 6'd0));
    drain_results();

    while (n_sent < NumItems) begin
      if (!paused_mid && n_sent >= 80) begin
        drain_results();
        paused_mid = 1'b1;
      end
      gaps_on = (n_sent < NumItems - 30);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        if ($urandom_range(0, 2) == 0) begin
          send_req(mk_req(REQ_CMD, 16'($urandom), rand_count(), 6'($urandom)));
        end else begin
          send_req(mk_req(REQ_DATA, 16'($urandom), rand_count(), 6'($urandom)));
          nraw = $urandom_range(0, 4);
          repeat (nraw) send_req(mk_req(REQ_RAW, 16'($urandom), rand_count(), 6'($urandom)));
          if ($urandom_range(0, 5) != 0) begin
            send_req(mk_req(REQ_END, 16'($urandom), rand_count(), 6'($urandom)));
          end
        end
      end else begin
        send_req(mk_req(req_kind_e'($urandom_range(0, 3)), 16'($urandom), rand_count(),
                        6'($urandom)));
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests: %0d raw, %0d command, %0d data start, %0d end.",
             n_sent, kind_cnt[REQ_RAW], kind_cnt[REQ_CMD], kind_cnt[REQ_DATA],
             kind_cnt[REQ_END]);
    $display("Checked %0d packed results against prediction.", n_results);
    if (n_errors == 0) begin
      $display("lcd_serial_frame_packer_top_tb: clean");
    end else begin
      $display("lcd_serial_frame_packer_top_tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/lcdsfp_pkg.sv
design/lcdsfp_front.sv
design/lcdsfp_queue.sv
design/lcdsfp_back.sv
design/lcd_serial_frame_packer_top.sv
bench/lcd_serial_frame_packer_checker.sv
bench/lcd_serial_frame_packer_top_tb.sv
